[rtl/mftc_pkg.sv]
// Shared constants, opcode and state types, and controller/datapath bundles
// for the multiset frequency-threshold counter. No dependencies.
`timescale 1ns / 1ps

package mftc_pkg;

   // Table geometry
   localparam int VALUE_RANGE = 4096;
   localparam int VAL_W       = $clog2(VALUE_RANGE);
   localparam int MAX_MULT    = 4096;
   localparam int MULT_W      = $clog2(MAX_MULT);
   localparam int BLOCK_SIZE  = 64;
   localparam int BLK_SHIFT   = $clog2(BLOCK_SIZE);
   localparam int NUM_BLOCKS  = MAX_MULT / BLOCK_SIZE;
   localparam int BLK_W       = MULT_W - BLK_SHIFT;

   // Field and counter widths
   localparam int OP_W  = 2;
   localparam int THR_W = 13;
   localparam int CNT_W = 13;
   localparam int IDX_W = MULT_W + 1;

   // Stream packing
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_BAD    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_DEC,
      ST_INC,
      ST_WALK,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;      // capture request fields
      logic clr_en;    // zero one entry of every table
      logic calc;      // compute new multiplicity, read both buckets
      logic upd_dec;   // write the old bucket back, decremented
      logic upd_inc;   // write the new bucket back, incremented
      logic walk_rd;   // issue one read of the query walk
      logic out_load;  // capture the response
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clr_last;
      logic refused;
      logic walk_done;
   } dp_status_type;

endpackage

[rtl/mftc_ctrl.sv]
// Controller state machine of the multiset frequency-threshold counter.
// Depends on mftc_pkg; drives mftc_dp through ctrl_cmd_type.
`timescale 1ns / 1ps

module mftc_ctrl
   import mftc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  op_type        req_opcode,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State and response-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               unique case (req_opcode)
                  OP_ADD, OP_REMOVE: state_in = ST_READ;
                  OP_QUERY:          state_in = ST_WALK;
                  OP_BAD:            state_in = ST_FINISH;
                  default:           state_in = ST_FINISH;
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = status.refused ? ST_FINISH : ST_DEC;
         end
         ST_DEC: begin
            cmd.upd_dec = 1'b1;
            state_in    = ST_INC;
         end
         ST_INC: begin
            cmd.upd_inc = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_WALK: begin
            // last read's data is summed on the same edge that ends the walk
            if (status.walk_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.walk_rd = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[rtl/mftc_dp.sv]
// Datapath of the multiset frequency-threshold counter: the three tables,
// the bucket update arithmetic, the query walk and the response register.
// Depends on mftc_pkg; commanded by mftc_ctrl.
`timescale 1ns / 1ps

module mftc_dp
   import mftc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   output dp_status_type     status,
   input  op_type            req_opcode,
   input  logic [VAL_W-1:0]  req_value,
   input  logic [THR_W-1:0]  req_threshold,
   output logic [CNT_W-1:0]  rsp_distinct_at_least,
   output logic              rsp_status
);

   // Tables
   logic [MULT_W-1:0] mult_mem [VALUE_RANGE];
   logic [CNT_W-1:0]  vpm_mem  [MAX_MULT];
   logic [CNT_W-1:0]  bs_mem   [NUM_BLOCKS];

   // Request and working registers
   op_type            op_ff;
   logic [VAL_W-1:0]  value_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [CNT_W-1:0]  acc_ff;
   logic [MULT_W-1:0] m_old_ff, m_new_ff;
   logic [MULT_W-1:0] clr_idx_ff;
   logic              pend_valid_ff, pend_blk_ff;
   logic              refused_ff;

   // Registered read data
   logic [MULT_W-1:0] mult_q_ff;
   logic [CNT_W-1:0]  vpm_qa_ff, vpm_qb_ff;
   logic [CNT_W-1:0]  bs_qa_ff, bs_qb_ff;

   // Response register
   logic [CNT_W-1:0]  out_count_ff;
   logic              out_status_ff;

   logic [THR_W-1:0]  thr_eff;
   logic              is_add, refused, blk_aligned, same_blk, rd_en;
   logic [MULT_W-1:0] m_cur, m_new;
   logic [MULT_W-1:0] vpm_ra;
   logic [BLK_W-1:0]  bs_ra;
   logic [CNT_W-1:0]  pend_data;
   logic [CNT_W:0]    acc_sum;

   logic              mult_we, vpm_we, bs_we;
   logic [MULT_W-1:0] mult_wa, vpm_wa;
   logic [BLK_W-1:0]  bs_wa;
   logic [MULT_W-1:0] mult_wd;
   logic [CNT_W-1:0]  vpm_wd, bs_wd;

   // Multiplicity update arithmetic
   assign m_cur   = mult_q_ff;
   assign is_add  = (op_ff == OP_ADD);
   assign refused = is_add ? (m_cur == MULT_W'(MAX_MULT - 1)) : (m_cur == '0);
   assign m_new   = is_add ? (m_cur + 1'b1) : (m_cur - 1'b1);
   assign same_blk = (m_old_ff[MULT_W-1:BLK_SHIFT] == m_new_ff[MULT_W-1:BLK_SHIFT]);

   // Query walk: single buckets up to a block boundary, then whole blocks
   assign thr_eff     = (req_threshold == '0) ? THR_W'(1) : req_threshold;
   assign blk_aligned = ((idx_ff % BLOCK_SIZE) == 0);
   assign pend_data   = pend_blk_ff ? bs_qa_ff : vpm_qa_ff;
   assign acc_sum     = {1'b0, acc_ff} + {1'b0, pend_data};

   assign status.clr_last  = (clr_idx_ff == MULT_W'(MAX_MULT - 1));
   assign status.refused   = refused;
   assign status.walk_done = (idx_ff >= IDX_W'(MAX_MULT));

   // Read port A serves the walk and the old bucket, port B the new bucket
   assign vpm_ra = cmd.calc ? m_cur : idx_ff[MULT_W-1:0];
   assign bs_ra  = cmd.calc ? m_cur[MULT_W-1:BLK_SHIFT] : idx_ff[MULT_W-1:BLK_SHIFT];
   assign rd_en  = cmd.calc || cmd.walk_rd;

   // Write port selection
   always_comb begin
      mult_we = 1'b0;
      mult_wa = value_ff;
      mult_wd = m_new;
      vpm_we  = 1'b0;
      vpm_wa  = m_old_ff;
      vpm_wd  = vpm_qa_ff - 1'b1;
      bs_we   = 1'b0;
      bs_wa   = m_old_ff[MULT_W-1:BLK_SHIFT];
      bs_wd   = bs_qa_ff - 1'b1;
      priority if (cmd.clr_en) begin
         mult_we = 1'b1;
         mult_wa = clr_idx_ff;
         mult_wd = '0;
         vpm_we  = 1'b1;
         vpm_wa  = clr_idx_ff;
         vpm_wd  = '0;
         bs_we   = 1'b1;
         bs_wa   = clr_idx_ff[BLK_W-1:0];
         bs_wd   = '0;
      end else if (cmd.calc) begin
         mult_we = !refused;
      end else if (cmd.upd_dec) begin
         // bucket zero is not counted
         vpm_we = (m_old_ff != '0);
         bs_we  = (m_old_ff != '0);
      end else if (cmd.upd_inc) begin
         vpm_we = (m_new_ff != '0);
         vpm_wa = m_new_ff;
         vpm_wd = vpm_qb_ff + 1'b1;
         bs_we  = (m_new_ff != '0);
         bs_wa  = m_new_ff[MULT_W-1:BLK_SHIFT];
         // undo the stale read when the decrement just hit this block
         bs_wd  = bs_qb_ff + 1'b1 - CNT_W'((m_old_ff != '0) && same_blk);
      end
   end

   // Memories
   always_ff @(posedge clock) begin
      if (mult_we) begin
         mult_mem[mult_wa] <= mult_wd;
      end
      mult_q_ff <= mult_mem[value_ff];
   end

   always_ff @(posedge clock) begin
      if (vpm_we) begin
         vpm_mem[vpm_wa] <= vpm_wd;
      end
      if (rd_en) begin
         vpm_qa_ff <= vpm_mem[vpm_ra];
         vpm_qb_ff <= vpm_mem[m_new];
      end
   end

   always_ff @(posedge clock) begin
      if (bs_we) begin
         bs_mem[bs_wa] <= bs_wd;
      end
      if (rd_en) begin
         bs_qa_ff <= bs_mem[bs_ra];
         bs_qb_ff <= bs_mem[m_new[MULT_W-1:BLK_SHIFT]];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff    <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_en) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
         pend_valid_ff <= cmd.walk_rd;
      end
   end

   // Request capture, update operands, walk index and accumulator
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         value_ff <= req_value;
         idx_ff   <= IDX_W'(thr_eff);
         acc_ff   <= '0;
      end else begin
         if (cmd.walk_rd) begin
            idx_ff      <= blk_aligned ? (idx_ff + IDX_W'(BLOCK_SIZE)) : (idx_ff + 1'b1);
            pend_blk_ff <= blk_aligned;
         end
         if (pend_valid_ff) begin
            acc_ff <= acc_sum[CNT_W] ? '1 : acc_sum[CNT_W-1:0];
         end
      end
      if (cmd.calc) begin
         m_old_ff   <= m_cur;
         m_new_ff   <= m_new;
         refused_ff <= refused;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         unique case (op_ff)
            OP_QUERY: begin
               out_count_ff  <= acc_ff;
               out_status_ff <= 1'b0;
            end
            OP_ADD, OP_REMOVE: begin
               out_count_ff  <= '0;
               out_status_ff <= refused_ff;
            end
            default: begin
               out_count_ff  <= '0;
               out_status_ff <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_distinct_at_least = out_count_ff;
   assign rsp_status            = out_status_ff;

endmodule

[rtl/multiset_freq_threshold_count.sv]
// Top level of the multiset frequency-threshold counter: stream ports,
// controller and datapath. Depends on mftc_pkg, mftc_ctrl and mftc_dp.
`timescale 1ns / 1ps

// Usage
//   req_* carries one request per handshake: add or remove one occurrence of
//   a value, or a query counting the distinct values seen at least threshold
//   times. rsp_* returns exactly one response per request, in order.
//   One request is worked at a time; req_tready is high only when idle.
//   Add/remove: from accept to the next accept the block reads the value's
//   multiplicity, reads both buckets, writes the old bucket, writes the new
//   bucket and loads the response. Refused updates and opcode 3 finish sooner.
//   Query: threshold rounded up to the next block boundary one bucket per
//   cycle, then one block sum per cycle to the top: up to 126 reads of the
//   bucket/block tables.
//   Reset clears all three tables by a sweep of all 4096 indices, one entry
//   per cycle, with req_tready low throughout.
//   The response sits in an output register. A stalled receiver holds it; a
//   new request is still accepted and worked, and its completion waits only
//   until the held response is taken.
module multiset_freq_threshold_count
   import mftc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [1:0] opcode, [13:2] value, [26:14] threshold, [31:27] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [12:0] distinct_at_least, [13] status, [15:14] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int VAL_LSB = OP_W;
   localparam int THR_LSB = OP_W + VAL_W;

   ctrl_cmd_type      cmd;
   dp_status_type     status;
   op_type            req_opcode;
   logic [CNT_W-1:0]  rsp_distinct_at_least;
   logic              rsp_status;

   assign req_opcode = op_type'(req_tdata[OP_W-1:0]);

   mftc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_opcode),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mftc_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_opcode            (req_opcode),
      .req_value             (req_tdata[VAL_LSB +: VAL_W]),
      .req_threshold         (req_tdata[THR_LSB +: THR_W]),
      .rsp_distinct_at_least (rsp_distinct_at_least),
      .rsp_status            (rsp_status)
   );

   assign rsp_tdata = {{(RSP_DATA_W - CNT_W - 1){1'b0}}, rsp_status, rsp_distinct_at_least};

`ifndef ASSERT_OFF
   // one request in flight: accepting closes the input until done
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous request in flight");

   // the new bucket is written only right after the old one
   a_inc_after_dec: assert property (@(posedge clock) disable iff (reset)
      cmd.upd_inc |-> $past(cmd.upd_dec))
      else $error("bucket increment without preceding decrement");

   // no request taken during the table clearing sweep
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_en |-> !req_tready)
      else $error("input open during clearing sweep");

   // a nonzero count only comes from a query, which is never refused
   a_count_not_refused: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[CNT_W-1:0] != '0)) |-> !rsp_tdata[CNT_W])
      else $error("refused response carries a count");
`endif

endmodule
